[rtl/core/assert_macros.svh]
// concurrent assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold on every clock edge out of reset
`define ASSERT_CHECK(lbl, prop, clk, rst_n) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: property failed");

// condition must never be seen out of reset
`define ASSERT_NEVER(lbl, cond, clk, rst_n) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_CHECK(lbl, prop, clk, rst_n)
`define ASSERT_NEVER(lbl, cond, clk, rst_n)

`endif

`endif

[rtl/core/sps_pkg.sv]
package sps_pkg;

  localparam int unsigned POS_W   = 16;
  localparam int unsigned FRAME_W = 16;
  localparam int unsigned SUM_W   = 20;
  localparam int unsigned CH_W    = 3;
  localparam int unsigned LINES_W = 8;
  localparam int unsigned SLOT_W  = 4;

  localparam logic [FRAME_W-1:0] FRAME_RESET    = 16'd40000;
  localparam logic [POS_W-1:0]   POSITION_RESET = 16'd3000;

  // operation codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [CH_W-1:0]   channel;
    logic [POS_W-1:0]  position;
  } item_t;

  typedef struct packed {
    logic [LINES_W-1:0] servo_lines;
    logic [SLOT_W-1:0]  slot;
    logic               frame_start;
  } result_t;

endpackage

[rtl/core/sps_step.sv]
`include "assert_macros.svh"

module sps_step #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_en_i,
  input  sps_pkg::item_t  item_i,
  input  logic [15:0]     frame_ticks_i,
  output sps_pkg::result_t result_o
);
  import sps_pkg::*;

  localparam int unsigned SlotW = $clog2(CHANNELS + 1);
  localparam int unsigned IdxW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [SlotW-1:0] Gap = SlotW'(CHANNELS);

  logic [POS_W-1:0]   positions_q [CHANNELS];
  logic [SlotW-1:0]   slot_q, slot_d;
  logic [POS_W-1:0]   ticks_left_q, ticks_left_d;
  logic [SUM_W-1:0]   frame_sum_q, frame_sum_d;

  logic [SlotW-1:0]      slot_next;
  logic [SUM_W-1:0]      sum_base;
  logic [SUM_W-1:0]      frame_wide;
  logic [IdxW+SlotW-1:0] rd_idx_w;
  logic [IdxW-1:0]       rd_idx;
  logic [IdxW+CH_W-1:0]  wr_idx_w;
  logic [IdxW-1:0]       wr_idx;
  logic [POS_W-1:0]      pos_rd;
  logic [POS_W-1:0]      chan_len;
  logic [POS_W-1:0]      gap_len;
  logic [POS_W-1:0]      len;
  logic                  pos_we;
  logic                  start;
  logic [SlotW+SLOT_W-1:0] slot_w;

  assign slot_next  = (slot_q == Gap) ? '0 : slot_q + SlotW'(1);
  // a new frame restarts the running sum
  assign sum_base   = (slot_q == Gap) ? '0 : frame_sum_q;
  assign frame_wide = {{(SUM_W - FRAME_W){1'b0}}, frame_ticks_i};

  assign rd_idx_w = {{IdxW{1'b0}}, slot_next};
  assign rd_idx   = rd_idx_w[IdxW-1:0];
  assign wr_idx_w = {{IdxW{1'b0}}, item_i.channel};
  assign wr_idx   = wr_idx_w[IdxW-1:0];

  assign pos_rd   = positions_q[rd_idx];
  assign chan_len = (pos_rd == '0) ? POS_W'(1) : pos_rd;
  // gap saturates at one tick once the pulses fill the frame
  assign gap_len  = (sum_base >= frame_wide) ? POS_W'(1)
                                             : POS_W'(frame_wide - sum_base);
  assign len      = (slot_next == Gap) ? gap_len : chan_len;

  always_comb begin
    slot_d       = slot_q;
    ticks_left_d = ticks_left_q;
    frame_sum_d  = frame_sum_q;
    pos_we       = 1'b0;
    start        = 1'b0;
    if (step_en_i) begin
      if (item_i.operation == OP_WRITE) begin
        pos_we = (32'(item_i.channel) < CHANNELS);
      end else if (ticks_left_q > POS_W'(1)) begin
        ticks_left_d = ticks_left_q - POS_W'(1);
      end else begin
        slot_d       = slot_next;
        start        = (slot_q == Gap);
        frame_sum_d  = sum_base + {{(SUM_W - POS_W){1'b0}}, len};
        ticks_left_d = len;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q       <= Gap;
      ticks_left_q <= POS_W'(1);
      frame_sum_q  <= '0;
    end else begin
      slot_q       <= slot_d;
      ticks_left_q <= ticks_left_d;
      frame_sum_q  <= frame_sum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        positions_q[c] <= POSITION_RESET;
      end
    end else if (pos_we) begin
      positions_q[wr_idx] <= item_i.position;
    end
  end

  assign slot_w = {{SLOT_W{1'b0}}, slot_d};

  always_comb begin
    for (int b = 0; b < LINES_W; b++) begin
      result_o.servo_lines[b] = (b < CHANNELS) && (32'(slot_d) == b);
    end
    result_o.slot        = slot_w[SLOT_W-1:0];
    result_o.frame_start = start;
  end

  `ASSERT_NEVER(a_slot_range, slot_q > Gap, clk_i, rst_ni)
  `ASSERT_NEVER(a_ticks_nonzero, ticks_left_q == '0, clk_i, rst_ni)
  `ASSERT_CHECK(a_start_after_gap, step_en_i && start |-> slot_q == Gap, clk_i, rst_ni)
  `ASSERT_CHECK(a_write_keeps_timing,
                step_en_i && item_i.operation == OP_WRITE |=>
                $stable(slot_q) && $stable(ticks_left_q) && $stable(frame_sum_q),
                clk_i, rst_ni)

endmodule

[rtl/core/servo_pulse_sequencer_core.sv]
// Servo pulse sequencer: drives CHANNELS servo lines one after another in a
// repeating frame. A tick transaction advances the slot timer by one 0.5 us
// tick; a write transaction stores one channel's pulse width, used the next
// time that channel's slot starts. Each transaction yields exactly one result
// holding the lines, the current slot (CHANNELS means the frame gap) and a
// frame start flag. It takes one transaction per clock unless out_ready_i
// stalls; input then result registers hold each, with the slot timer's
// 20-bit compare, subtract and add between. The user, not the block, writes
// frame_ticks via cfg_we_i/cfg_wdata_i only with no transaction in flight.
module servo_pulse_sequencer_core #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [2:0]  channel_i,
  input  logic [15:0] position_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  servo_lines_o,
  output logic [3:0]  slot_o,
  output logic        frame_start_o
);
  import sps_pkg::*;

  logic [FRAME_W-1:0] frame_ticks_q;
  logic               s1_valid_q;
  item_t              s1_item_q;
  logic               out_valid_q;
  result_t            out_res_q;
  result_t            step_res;
  logic               out_free;
  logic               s1_fire;
  logic               in_fire;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_ticks_q <= FRAME_RESET;
    end else if (cfg_we_i) begin
      frame_ticks_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q.operation <= operation_i;
      s1_item_q.channel   <= channel_i;
      s1_item_q.position  <= position_i;
    end
    if (s1_fire) begin
      out_res_q <= step_res;
    end
  end

  sps_step #(
    .CHANNELS(CHANNELS)
  ) u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_en_i    (s1_fire),
    .item_i       (s1_item_q),
    .frame_ticks_i(frame_ticks_q),
    .result_o     (step_res)
  );

  assign out_valid_o   = out_valid_q;
  assign servo_lines_o = out_res_q.servo_lines;
  assign slot_o        = out_res_q.slot;
  assign frame_start_o = out_res_q.frame_start;

endmodule

[bench/tb_top.sv]
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sps_pkg::*;

  localparam int NUM_CH = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic             cfg_we = 1'b0;
  logic [15:0]      cfg_wdata = '0;
  logic             in_valid = 1'b0;
  item_t            in_item = '0;
  logic             out_ready = 1'b0;
  logic             recv_hold = 1'b0;
  int unsigned      send_idle_pct = 0;
  int unsigned      stall_pct = 0;

  logic             in_ready_o;
  logic             out_valid_o;
  logic [7:0]       servo_lines_o;
  logic [3:0]       slot_o;
  logic             frame_start_o;

  item_t            pending_items[$];
  result_t          expected_results[$];
  int               error_count = 0;

  // sequencer state as the block should hold it
  logic [POS_W-1:0]   pos_store[NUM_CH];
  logic [SLOT_W-1:0]  cur_slot;
  logic [POS_W-1:0]   ticks_remaining;
  logic [SUM_W-1:0]   frame_accum;
  logic [FRAME_W-1:0] frame_period;

  always #5 clk_i = ~clk_i;

  servo_pulse_sequencer_core #(
    .CHANNELS(NUM_CH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .operation_i  (in_item.operation),
    .channel_i    (in_item.channel),
    .position_i   (in_item.position),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .servo_lines_o(servo_lines_o),
    .slot_o       (slot_o),
    .frame_start_o(frame_start_o)
  );

  function automatic result_t advance_sequencer(item_t it);
    result_t        r;
    logic [POS_W-1:0] len;
    r = '0;
    if (it.operation == OP_WRITE) begin
      pos_store[it.channel] = it.position;
    end else if (ticks_remaining > 1) begin
      ticks_remaining = ticks_remaining - 1'b1;
    end else begin
      if (cur_slot == NUM_CH) begin
        cur_slot = '0;
        frame_accum = '0;
        r.frame_start = 1'b1;
      end else begin
        cur_slot = cur_slot + 1'b1;
      end
      if (cur_slot == NUM_CH) begin
        // gap fills the rest of the frame, one tick once the pulses use it up
        if (frame_accum >= frame_period) len = POS_W'(1);
        else len = frame_period - frame_accum[FRAME_W-1:0];
      end else begin
        len = (pos_store[cur_slot[CH_W-1:0]] == 0) ? POS_W'(1)
                                                    : pos_store[cur_slot[CH_W-1:0]];
      end
      frame_accum = frame_accum + len;
      ticks_remaining = len;
    end
    r.servo_lines = (cur_slot < NUM_CH) ? (8'd1 << cur_slot) : 8'd0;
    r.slot = cur_slot;
    return r;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) expected_results.push_back(advance_sequencer(in_item));
      if (!in_valid || in_ready_o) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_item  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_res;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected transaction: lines %h slot %0d start %0d",
                 servo_lines_o, slot_o, frame_start_o);
          error_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (servo_lines_o !== exp_res.servo_lines) begin
            $error("servo_lines: expected %h, got %h", exp_res.servo_lines, servo_lines_o);
            error_count++;
          end
          if (slot_o !== exp_res.slot) begin
            $error("slot: expected %0d, got %0d", exp_res.slot, slot_o);
            error_count++;
          end
          if (frame_start_o !== exp_res.frame_start) begin
            $error("frame_start: expected %0d, got %0d", exp_res.frame_start, frame_start_o);
            error_count++;
          end
        end
      end
      if (recv_hold) out_ready <= 1'b0;
      else out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic item_t make_item(logic op, logic [CH_W-1:0] ch, logic [POS_W-1:0] pos);
    item_t it;
    it.operation = op;
    it.channel   = ch;
    it.position  = pos;
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_frame(logic [FRAME_W-1:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    frame_period = value;
  endtask

  task automatic queue_random_items(int count);
    int unsigned      roll;
    logic [CH_W-1:0]  ch;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      ch = CH_W'($urandom_range(0, NUM_CH - 1));
      if (roll < 75) begin
        // channel and position are ignored on a tick, so fill them with noise
        pending_items.push_back(make_item(OP_TICK, CH_W'($urandom), POS_W'($urandom)));
      end else if (roll < 95) begin
        pending_items.push_back(make_item(OP_WRITE, ch, POS_W'($urandom_range(0, 12))));
      end else begin
        // wide value, replaced before its slot comes round so the frame stays short
        pending_items.push_back(make_item(OP_WRITE, ch, POS_W'($urandom)));
        pending_items.push_back(make_item(OP_WRITE, ch, POS_W'($urandom_range(0, 12))));
        i++;
      end
    end
  endtask

  task automatic run_phase(logic [FRAME_W-1:0] frame, int unsigned idle_pct,
                           int unsigned hold_pct, int count);
    wait_drained();
    write_frame(frame);
    send_idle_pct <= idle_pct;
    stall_pct     <= hold_pct;
    queue_random_items(count);
  endtask

  initial begin
    for (int c = 0; c < NUM_CH; c++) pos_store[c] = POSITION_RESET;
    cur_slot        = SLOT_W'(NUM_CH);
    ticks_remaining = POS_W'(1);
    frame_accum     = '0;
    frame_period    = FRAME_RESET;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // short pulses first, so the first frame never sits in the default long gap
    pending_items.push_back(make_item(OP_WRITE, 3'd0, 16'd0));
    pending_items.push_back(make_item(OP_WRITE, 3'd1, 16'd1));
    pending_items.push_back(make_item(OP_WRITE, 3'd2, 16'd2));
    pending_items.push_back(make_item(OP_WRITE, 3'd3, 16'hffff));
    pending_items.push_back(make_item(OP_WRITE, 3'd3, 16'd2));
    pending_items.push_back(make_item(OP_WRITE, 3'd4, 16'd3));
    pending_items.push_back(make_item(OP_WRITE, 3'd5, 16'd3));
    pending_items.push_back(make_item(OP_WRITE, 3'd6, 16'd2));
    pending_items.push_back(make_item(OP_WRITE, 3'd7, 16'd3));
    for (int i = 0; i < 8; i++)
      pending_items.push_back(make_item(OP_TICK, (i % 2) ? 3'd7 : 3'd0,
                                        (i % 2) ? 16'hffff : 16'h0000));
    // channel 5 rewritten while its slot is still ahead
    pending_items.push_back(make_item(OP_WRITE, 3'd5, 16'd4));
    pending_items.push_back(make_item(OP_TICK, 3'd0, 16'd0));

    // pulses written above sum to 18, so with no later write the gap is 2 ticks
    run_phase(16'd20, 0, 0, 250);
    fork
      begin
        recv_hold <= 1'b1;
        repeat (300) @(posedge clk_i);
        recv_hold <= 1'b0;
      end
    join_none
    // period shorter than any frame: gap always one tick
    run_phase(16'd1, 73, 0, 200);
    run_phase(FRAME_W'($urandom_range(1, 100)), 0, 73, 250);
    run_phase(FRAME_W'($urandom_range(1, 100)), 13, 13, 250);
    run_phase(16'hffff, 13, 13, 100);

    wait_drained();
    repeat (6) @(posedge clk_i);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+rtl/core
rtl/core/sps_pkg.sv
rtl/core/sps_step.sv
rtl/core/servo_pulse_sequencer_core.sv
bench/tb_top.sv
